FILE: hw/rtl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam logic [2:0]  FRAME_LAST = 3'd6;

    localparam logic [9:0]         HUM_SCALE   = 10'd1000;
    localparam logic [10:0]        TEMP_SCALE  = 11'd2000;
    localparam logic signed [11:0] TEMP_OFFSET = 12'sd500;

    // Completed frame handed from the assembler to the scaling stage.
    typedef struct packed {
        logic [19:0] hum_raw;
        logic [19:0] temp_raw;
        logic        crc_ok;
        logic [7:0]  crc6;
        logic [7:0]  status;
    } frame_t;

    // One byte through the CRC-8 register, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/humidity_temperature_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder
// Decodes seven-byte sensor frames into humidity and temperature in tenths.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result register has room, set by the
// byte-wide CRC update in the assembler, which runs once per byte.
// The seventh byte passes the input register, then its result item is registered in the scaling stage.
// Reset is asynchronous and active low; it clears the pipeline valids and
// restarts the frame at the status byte with the CRC at its initial value.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [9:0]          humidity_tenths,
    output logic signed [11:0]  temperature_tenths,
    output logic                crc_ok,
    output logic [7:0]          computed_crc,
    output logic [7:0]          sensor_status
);

    logic             res_valid;
    logic             res_ready;
    htfd_pkg::frame_t res_frame;

    htfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_frame   (res_frame)
    );

    htfd_scale u_scale (
        .clk                (clk),
        .rst_n              (rst_n),
        .res_valid          (res_valid),
        .res_ready          (res_ready),
        .res_frame          (res_frame),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths),
        .crc_ok             (crc_ok),
        .computed_crc       (computed_crc),
        .sensor_status      (sensor_status)
    );

endmodule

FILE: hw/rtl/htfd_frame.sv
// ----------------------------------------------------------------------------
// htfd_frame
// Input register, byte position, running CRC and raw field assembly.
// ----------------------------------------------------------------------------
module htfd_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    input  logic              frame_start,
    output logic              res_valid,
    input  logic              res_ready,
    output htfd_pkg::frame_t  res_frame
);

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_start_reg;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  crc6_reg, crc6_next;
    logic [19:0] hum_reg, hum_next;
    logic [19:0] temp_reg, temp_next;
    logic [7:0]  status_reg, status_next;

    logic [2:0]  pos_eff;
    logic [7:0]  crc_eff;
    logic [7:0]  crc_new;
    logic        is_last;
    logic        adv;
    logic        accept;

    // A start byte restarts position and CRC before it is taken.
    assign pos_eff = s1_start_reg ? 3'd0 : pos_reg;
    assign crc_eff = s1_start_reg ? htfd_pkg::CRC_INIT : crc_reg;
    assign crc_new = htfd_pkg::crc8_byte(crc_eff, s1_byte_reg);
    assign is_last = (pos_eff == htfd_pkg::FRAME_LAST);

    // Only the byte that completes a frame needs room in the result register.
    assign adv      = s1_valid_reg && (!is_last || res_ready);
    assign in_stall = s1_valid_reg && !adv;
    assign accept   = in_valid && !in_stall;

    assign res_valid           = s1_valid_reg && is_last;
    assign res_frame.hum_raw   = hum_reg;
    assign res_frame.temp_raw  = temp_reg;
    assign res_frame.crc_ok    = (crc_new == 8'h00);
    assign res_frame.crc6      = crc6_reg;
    assign res_frame.status    = status_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        crc6_next   = crc6_reg;
        hum_next    = hum_reg;
        temp_next   = temp_reg;
        status_next = status_reg;
        if (adv && (pos_eff <= htfd_pkg::FRAME_LAST))
        begin
            if (is_last)
            begin
                pos_next = 3'd0;
                crc_next = htfd_pkg::CRC_INIT;
            end
            else
            begin
                pos_next = pos_eff + 3'd1;
                crc_next = crc_new;
            end
            case (pos_eff)
                3'd0:
                begin
                    status_next = s1_byte_reg;
                end
                3'd1:
                begin
                    hum_next = {s1_byte_reg, 12'h000};
                end
                3'd2:
                begin
                    hum_next = hum_reg | {8'h00, s1_byte_reg, 4'h0};
                end
                3'd3:
                begin
                    hum_next  = hum_reg | {16'h0000, s1_byte_reg[7:4]};
                    temp_next = {s1_byte_reg[3:0], 16'h0000};
                end
                3'd4:
                begin
                    temp_next = temp_reg | {4'h0, s1_byte_reg, 8'h00};
                end
                3'd5:
                begin
                    temp_next = temp_reg | {12'h000, s1_byte_reg};
                    crc6_next = crc_new;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pos_reg      <= 3'd0;
            crc_reg      <= htfd_pkg::CRC_INIT;
            crc6_reg     <= 8'h00;
            hum_reg      <= 20'h00000;
            temp_reg     <= 20'h00000;
            status_reg   <= 8'h00;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            crc6_reg     <= crc6_next;
            hum_reg      <= hum_next;
            temp_reg     <= temp_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= rx_byte;
            s1_start_reg <= frame_start;
        end
    end

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= htfd_pkg::FRAME_LAST)
        else $error("byte position beyond the last frame byte");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && is_last) |=> (pos_reg == 3'd0 && crc_reg == htfd_pkg::CRC_INIT))
        else $error("frame did not restart after its last byte");

    a_stall_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && is_last && !res_ready))
        else $error("input stalled without a blocked result");
`endif

endmodule

FILE: hw/rtl/htfd_scale.sv
// ----------------------------------------------------------------------------
// htfd_scale
// Converts raw fields to tenths and holds the result item for the output.
// ----------------------------------------------------------------------------
module htfd_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    output logic                res_ready,
    input  htfd_pkg::frame_t    res_frame,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [9:0]          humidity_tenths,
    output logic signed [11:0]  temperature_tenths,
    output logic                crc_ok,
    output logic [7:0]          computed_crc,
    output logic [7:0]          sensor_status
);

    logic               out_valid_reg, out_valid_next;
    logic [9:0]         hum_reg, hum_next;
    logic signed [11:0] temp_reg, temp_next;
    logic               ok_reg;
    logic [7:0]         crc6_reg;
    logic [7:0]         status_reg;

    logic [29:0] hum_prod;
    logic [30:0] temp_prod;
    logic        load;

    assign hum_prod  = res_frame.hum_raw * htfd_pkg::HUM_SCALE;
    assign temp_prod = res_frame.temp_raw * htfd_pkg::TEMP_SCALE;

    assign res_ready = !out_valid_reg || !out_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        // A failed CRC gives zero for both measured values.
        if (res_frame.crc_ok)
        begin
            hum_next  = hum_prod[29:20];
            temp_next = $signed({1'b0, temp_prod[30:20]}) - htfd_pkg::TEMP_OFFSET;
        end
        else
        begin
            hum_next  = 10'd0;
            temp_next = 12'sd0;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hum_reg    <= hum_next;
            temp_reg   <= temp_next;
            ok_reg     <= res_frame.crc_ok;
            crc6_reg   <= res_frame.crc6;
            status_reg <= res_frame.status;
        end
    end

    assign out_valid          = out_valid_reg;
    assign humidity_tenths    = hum_reg;
    assign temperature_tenths = temp_reg;
    assign crc_ok             = ok_reg;
    assign computed_crc       = crc6_reg;
    assign sensor_status      = status_reg;

`ifndef SYNTH
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |-> (hum_reg == 10'd0 && temp_reg == 12'sd0))
        else $error("failed frame carries non-zero values");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hum_reg <= 10'd999))
        else $error("humidity beyond full scale");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ok_reg) |-> (temp_reg >= -12'sd500 && temp_reg <= 12'sd1499))
        else $error("temperature beyond full scale");
`endif

endmodule

FILE: tb/tb_humidity_temperature_frame_decoder.sv
// ----------------------------------------------------------------------------
// tb_humidity_temperature_frame_decoder
// Self-checking bench for the seven-byte sensor frame decoder. Bytes are fed
// as whole frames with a valid CRC, frames with a corrupted CRC, frames cut
// short by a new frame start, and loose noise bytes. Each accepted byte goes
// through a scoreboard that tracks the frame and predicts the decoded
// reading, which is then compared field by field with each accepted result.
// ----------------------------------------------------------------------------
module tb_humidity_temperature_frame_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASE_FRAMES = 75;
    localparam int HOLD_CYCLES  = 200;

    typedef logic [6:0][7:0] frame_bytes_t;

    typedef struct packed {
        logic [9:0]         hum;
        logic signed [11:0] temp;
        logic               ok;
        logic [7:0]         crc6;
        logic [7:0]         status;
    } reading_t;

    class frame_scoreboard;
        reading_t   reading_q[$];
        int         errors;
        logic [2:0] pos;
        logic [7:0] crc;
        logic [7:0] crc6;
        logic [19:0] hum_raw;
        logic [19:0] temp_raw;
        logic [7:0] status;

        function new();
            errors   = 0;
            pos      = 3'd0;
            crc      = htfd_pkg::CRC_INIT;
            crc6     = 8'h00;
            hum_raw  = 20'h0;
            temp_raw = 20'h0;
            status   = 8'h00;
        endfunction

        function logic [7:0] crc_update(input logic [7:0] c_in, input logic [7:0] b);
            logic [7:0] c;
            c = c_in ^ b;
            for (int k = 0; k < 8; k++)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY) : {c[6:0], 1'b0};
            end
            return c;
        endfunction

        function int pending();
            return reading_q.size();
        endfunction

        function void note_input(input logic [7:0] b, input logic fs);
            reading_t   r;
            logic [63:0] hum_prod;
            logic [63:0] temp_prod;
            if (fs)
            begin
                pos = 3'd0;
                crc = htfd_pkg::CRC_INIT;
            end
            if (pos > htfd_pkg::FRAME_LAST)
            begin
                return;
            end
            crc = crc_update(crc, b);
            case (pos)
                3'd0: status = b;
                3'd1: hum_raw = {b, 12'h000};
                3'd2: hum_raw = hum_raw | {8'h00, b, 4'h0};
                3'd3:
                begin
                    hum_raw  = hum_raw | {16'h0000, b[7:4]};
                    temp_raw = {b[3:0], 16'h0000};
                end
                3'd4: temp_raw = temp_raw | {4'h0, b, 8'h00};
                3'd5:
                begin
                    temp_raw = temp_raw | {12'h000, b};
                    crc6     = crc;
                end
                default: ;
            endcase
            if (pos < htfd_pkg::FRAME_LAST)
            begin
                pos = pos + 3'd1;
                return;
            end
            // Seventh byte: the CRC over the whole frame must come out at zero.
            r.ok     = (crc == 8'h00);
            r.crc6   = crc6;
            r.status = status;
            if (r.ok)
            begin
                hum_prod  = {44'h0, hum_raw} * 64'd1000;
                temp_prod = {44'h0, temp_raw} * 64'd2000;
                r.hum     = hum_prod[29:20];
                r.temp    = temp_prod[31:20] - 12'd500;
            end
            else
            begin
                r.hum  = 10'd0;
                r.temp = 12'sd0;
            end
            reading_q.push_back(r);
            pos = 3'd0;
            crc = htfd_pkg::CRC_INIT;
        endfunction

        function void check_result(input reading_t got);
            reading_t exp_r;
            if (reading_q.size() == 0)
            begin
                $display("%0t: result item with no reading pending", $time);
                errors++;
                return;
            end
            exp_r = reading_q.pop_front();
            if (got.hum !== exp_r.hum)
            begin
                $display("%0t: humidity_tenths expected %0d actual %0d",
                         $time, exp_r.hum, got.hum);
                errors++;
            end
            if (got.temp !== exp_r.temp)
            begin
                $display("%0t: temperature_tenths expected %0d actual %0d",
                         $time, exp_r.temp, got.temp);
                errors++;
            end
            if (got.ok !== exp_r.ok)
            begin
                $display("%0t: crc_ok expected %0b actual %0b", $time, exp_r.ok, got.ok);
                errors++;
            end
            if (got.crc6 !== exp_r.crc6)
            begin
                $display("%0t: computed_crc expected %02h actual %02h",
                         $time, exp_r.crc6, got.crc6);
                errors++;
            end
            if (got.status !== exp_r.status)
            begin
                $display("%0t: sensor_status expected %02h actual %02h",
                         $time, exp_r.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               frame_start;
    logic               out_valid;
    logic               out_stall;
    logic [9:0]         humidity_tenths;
    logic signed [11:0] temperature_tenths;
    logic               crc_ok;
    logic [7:0]         computed_crc;
    logic [7:0]         sensor_status;

    frame_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_req;
    int  quiet_cycles;
    bit  need_start;

    humidity_temperature_frame_decoder DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .rx_byte            (rx_byte),
        .frame_start        (frame_start),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths),
        .crc_ok             (crc_ok),
        .computed_crc       (computed_crc),
        .sensor_status      (sensor_status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Sampling on the falling edge sees the values that the next rising edge acts on.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_result({humidity_tenths, temperature_tenths, crc_ok,
                                 computed_crc, sensor_status});
            end
            if (in_valid && !in_stall)
            begin
                sb.note_input(rx_byte, frame_start);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(255));
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= fs;
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Sends the first n bytes of a frame; frame_start only on the status byte.
    task automatic send_frame(input frame_bytes_t fr, input int n, input bit with_start);
        for (int i = 0; i < n; i++)
        begin
            send_byte(fr[i], (i == 0) && with_start);
        end
    endtask

    function automatic frame_bytes_t seal_frame(input frame_bytes_t fr);
        frame_bytes_t f;
        logic [7:0]   c;
        f = fr;
        c = htfd_pkg::CRC_INIT;
        for (int i = 0; i < 6; i++)
        begin
            c = sb.crc_update(c, f[i]);
        end
        f[6] = c;
        return f;
    endfunction

    function automatic frame_bytes_t random_frame();
        frame_bytes_t f;
        int           shape;
        shape = $urandom_range(9);
        for (int i = 0; i < 7; i++)
        begin
            f[i] = 8'($urandom_range(255));
        end
        // Now and then push the data bytes to the ends of the scale.
        if (shape == 0)
        begin
            for (int i = 1; i < 6; i++)
            begin
                f[i] = 8'h00;
            end
        end
        else if (shape == 1)
        begin
            for (int i = 1; i < 6; i++)
            begin
                f[i] = 8'hFF;
            end
        end
        return seal_frame(f);
    endfunction

    task automatic random_phase();
        frame_bytes_t f;
        int           kind;
        int           cut;
        for (int n = 0; n < PHASE_FRAMES; n++)
        begin
            kind = $urandom_range(99);
            f    = random_frame();
            if (kind < 76)
            begin
                // Back-to-back frames may leave frame_start low.
                send_frame(f, 7, need_start || ($urandom_range(2) != 0));
                need_start = 1'b0;
            end
            else if (kind < 86)
            begin
                f[6] = f[6] ^ 8'($urandom_range(1, 255));
                send_frame(f, 7, need_start || ($urandom_range(1) != 0));
                need_start = 1'b0;
            end
            else if (kind < 93)
            begin
                cut = $urandom_range(1, 6);
                send_frame(f, cut, 1'b1);
                need_start = 1'b1;
            end
            else
            begin
                cut = $urandom_range(1, 8);
                for (int i = 0; i < cut; i++)
                begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                need_start = 1'b1;
            end
        end
    endtask

    initial
    begin
        frame_bytes_t f;
        sb            = new();
        send_idle_pct = 24;
        recv_idle_pct = 72;
        hold_req      = 0;
        quiet_cycles  = 0;
        need_start    = 1'b1;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        frame_start   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lowest reading: status and data all zero.
        f = seal_frame('0);
        send_frame(f, 7, 1'b1);
        // Highest reading, sent straight after without a frame start.
        f = seal_frame({8'h00, {6{8'hFF}}});
        send_frame(f, 7, 1'b0);
        // A frame cut short by a new frame start, which then has a broken CRC.
        f = seal_frame({8'h00, 8'h5A, 8'h3C, 8'hA5, 8'h96, 8'h69, 8'h1C});
        send_frame(f, 3, 1'b1);
        f[6] = f[6] ^ 8'h01;
        send_frame(f, 7, 1'b1);

        random_phase();

        send_idle_pct = 72;
        recv_idle_pct = 24;
        random_phase();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Long receiver hold-off while bytes keep coming, so the block backs up.
        hold_req++;
        random_phase();

        in_valid <= 1'b0;
        while (sb.pending() > 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_frame.sv
hw/rtl/htfd_scale.sv
hw/rtl/humidity_temperature_frame_decoder.sv
tb/tb_humidity_temperature_frame_decoder.sv
